// ===== src/byte_stuffed_frame_receiver_assert.svh =====
// Assertion macros for the byte-stuffed frame receiver.
// Used by the top level only; needs clk and arst_n in the including scope.
`ifndef BYTE_STUFFED_FRAME_RECEIVER_ASSERT_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSFR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bsfr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BSFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bsfr: next-cycle check failed");

`endif

// ===== src/bsfr_pkg.sv =====
// Shared types and constants for the byte-stuffed frame receiver.
// No dependencies; used by every module of the block.
package bsfr_pkg;

	// Raw-byte buffer size and the width of the raw byte counter.
	localparam int BUFFER_BYTES = 256;
	localparam int RAW_W        = $clog2(BUFFER_BYTES);

	// Event queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Frame end status codes.
	localparam logic [2:0] ST_GOOD     = 3'd0;
	localparam logic [2:0] ST_BADSUM   = 3'd1;
	localparam logic [2:0] ST_SHORT    = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_RESTART  = 3'd4;
	localparam logic [2:0] ST_DANGLING = 3'd5;

	// Item kinds.
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_START  = 2'd0;
	localparam logic [1:0] CFG_STOP   = 2'd1;
	localparam logic [1:0] CFG_ESCAPE = 2'd2;
	localparam logic [1:0] CFG_OFFSET = 2'd3;

	// One classified event from the front: an optional result item and counter steps.
	typedef struct packed {
		logic       emit;
		logic       kind;
		logic [7:0] data_byte;
		logic       is_id;
		logic [2:0] status;
		logic       inc_total;
		logic       inc_good;
		logic       inc_ovf;
	} event_t;

endpackage

// ===== src/byte_stuffed_frame_receiver.sv =====
// Byte-stuffed frame receiver with an additive 8-bit checksum.
// Input stream s_*: one raw serial byte per item in s_tdata[7:0].
// Output stream m_*: m_tuser is the kind (0 data byte, 1 frame end status);
// m_tlast is high on every status item, each of which closes a frame.
// Data items carry the unescaped id and payload bytes; the checksum byte is
// held back and checked at the stop byte. Status items report good, bad
// checksum, too short, overflow abort, restart abort or dangling escape.
// The three 32-bit counters in m_tdata wrap and show their values after the
// item's own update.
// Configuration: cfg_we with cfg_index (0 start, 1 stop, 2 escape, 3 offset)
// and cfg_data; write only while the block is idle.
// Throughput is one item per cycle while the queue has room: the front classifies an item
// combinationally and the back drains one queue entry per cycle while m_tready allows it.
// A result passes through the queue and then the output register before it is valid.
// A four-entry event queue absorbs a stall
// on m_tready; once it is full s_tready drops until the back drains it.
// Reset restores the default control bytes, closes any frame and clears the
// counters; no output item is pending afterwards.
module byte_stuffed_frame_receiver (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] rx_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] data_byte, [8] is_id, [11:9] status, [43:12] frames_total,
	// [75:44] frames_good, [107:76] overflows, [111:108] zero
	output logic [111:0] m_tdata,
	output logic         m_tuser,  // [0] kind
	output logic         m_tlast
);

	logic                          q_full, q_not_empty, push, pop;
	bsfr_pkg::event_t              push_ev, head_ev;
	logic [bsfr_pkg::QCNT_W-1:0]   q_count;
	logic                          kind;
	logic [7:0]                    data_byte;
	logic                          is_id;
	logic [2:0]                    status;
	logic [31:0]                   frames_total, frames_good, overflows;

	bsfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.rx_byte   (s_tdata),
		.q_full    (q_full),
		.in_ready  (s_tready),
		.push      (push),
		.ev        (push_ev)
	);

	bsfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ev   (push_ev),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_ev   (head_ev),
		.count     (q_count)
	);

	bsfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_valid     (q_not_empty),
		.ev           (head_ev),
		.pop          (pop),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.kind         (kind),
		.data_byte    (data_byte),
		.is_id        (is_id),
		.status       (status),
		.frames_total (frames_total),
		.frames_good  (frames_good),
		.overflows    (overflows)
	);

	// Pack the output item.
	assign m_tdata = {4'b0000, overflows, frames_good, frames_total, status, is_id, data_byte};
	assign m_tuser = kind;
	assign m_tlast = kind;

	`include "byte_stuffed_frame_receiver_assert.svh"

	// The queue is never written while it is full.
	`BSFR_ASSERT_NOW(a_no_push_full, push, q_count != bsfr_pkg::QCNT_W'(bsfr_pkg::QUEUE_DEPTH))
	// Input back-pressure comes only from a full queue.
	`BSFR_ASSERT_NOW(a_ready_full, !s_tready, q_full)
	// A data item carries a good status code and never closes a frame.
	`BSFR_ASSERT_NOW(a_data_clean, m_tvalid && !m_tuser, (status == bsfr_pkg::ST_GOOD) && !m_tlast)
	// Every popped queue entry that carries an item shows it on the output.
	`BSFR_ASSERT_NEXT(a_pop_result, pop && head_ev.emit, m_tvalid)

endmodule

// ===== src/bsfr_front.sv =====
// Front end: holds configuration and frame state, classifies each received item.
// Depends on bsfr_pkg; feeds bsfr_queue.
module bsfr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	input  logic [7:0]           rx_byte,
	input  logic                 q_full,
	output logic                 in_ready,
	output logic                 push,
	output bsfr_pkg::event_t     ev
);

	logic [7:0] start_q, stop_q, escape_q, offset_q;

	logic                       in_frame_q, esc_q, held_valid_q, id_pend_q;
	logic [bsfr_pkg::RAW_W-1:0] raw_q;
	logic [7:0]                 held_q, sum_q;

	logic                       in_frame_d, esc_d, held_valid_d, id_pend_d;
	logic [bsfr_pkg::RAW_W-1:0] raw_d;
	logic [7:0]                 held_d, sum_d;
	logic                       take_value;
	logic [7:0]                 value;
	logic                       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= 8'd2;
			stop_q   <= 8'd3;
			escape_q <= 8'd16;
			offset_q <= 8'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsfr_pkg::CFG_START:  start_q  <= cfg_data;
				bsfr_pkg::CFG_STOP:   stop_q   <= cfg_data;
				bsfr_pkg::CFG_ESCAPE: escape_q <= cfg_data;
				bsfr_pkg::CFG_OFFSET: offset_q <= cfg_data;
				default:              start_q  <= start_q;
			endcase
		end
	end

	// Classification of one item and the next frame state.
	always_comb begin
		in_frame_d   = in_frame_q;
		esc_d        = esc_q;
		held_valid_d = held_valid_q;
		id_pend_d    = id_pend_q;
		raw_d        = raw_q;
		held_d       = held_q;
		sum_d        = sum_q;
		ev           = '0;
		take_value   = 1'b0;
		value        = rx_byte;

		priority if (raw_q == bsfr_pkg::RAW_W'(bsfr_pkg::BUFFER_BYTES - 1)) begin
			// Buffer full: the byte is dropped and any open frame is aborted.
			ev.inc_ovf   = 1'b1;
			ev.emit      = in_frame_q;
			ev.kind      = bsfr_pkg::KIND_STATUS;
			ev.status    = bsfr_pkg::ST_OVERFLOW;
			in_frame_d   = 1'b0;
			esc_d        = 1'b0;
			held_valid_d = 1'b0;
			id_pend_d    = 1'b0;
			raw_d        = '0;
		end else if (rx_byte == start_q) begin
			// Start byte: a frame still open is reported as restarted.
			ev.emit      = in_frame_q;
			ev.kind      = bsfr_pkg::KIND_STATUS;
			ev.status    = bsfr_pkg::ST_RESTART;
			in_frame_d   = 1'b1;
			esc_d        = 1'b0;
			held_valid_d = 1'b0;
			id_pend_d    = 1'b1;
			raw_d        = bsfr_pkg::RAW_W'(1);
			sum_d        = 8'd0;
		end else if (rx_byte == stop_q) begin
			// Stop byte: close the frame and judge it.
			if (in_frame_q) begin
				ev.emit = 1'b1;
				ev.kind = bsfr_pkg::KIND_STATUS;
				priority if (raw_q < bsfr_pkg::RAW_W'(2)) begin
					ev.status = bsfr_pkg::ST_SHORT;
				end else if (esc_q) begin
					ev.inc_total = 1'b1;
					ev.status    = bsfr_pkg::ST_DANGLING;
				end else if (!held_valid_q) begin
					ev.inc_total = 1'b1;
					ev.status    = bsfr_pkg::ST_SHORT;
				end else if (sum_q == held_q) begin
					ev.inc_total = 1'b1;
					ev.inc_good  = 1'b1;
					ev.status    = bsfr_pkg::ST_GOOD;
				end else begin
					ev.inc_total = 1'b1;
					ev.status    = bsfr_pkg::ST_BADSUM;
				end
			end
			in_frame_d   = 1'b0;
			esc_d        = 1'b0;
			held_valid_d = 1'b0;
			id_pend_d    = 1'b0;
			raw_d        = '0;
		end else begin
			// Ordinary byte: unescape inside a frame.
			raw_d = raw_q + bsfr_pkg::RAW_W'(1);
			if (in_frame_q) begin
				priority if (esc_q) begin
					value      = rx_byte + offset_q;
					esc_d      = 1'b0;
					take_value = 1'b1;
				end else if (rx_byte == escape_q) begin
					esc_d = 1'b1;
				end else begin
					take_value = 1'b1;
				end
			end
		end

		// A new value releases the one held back, which was not the checksum.
		if (take_value) begin
			if (held_valid_q) begin
				ev.emit      = 1'b1;
				ev.kind      = bsfr_pkg::KIND_DATA;
				ev.data_byte = held_q;
				ev.is_id     = id_pend_q;
				sum_d        = sum_q + held_q;
				id_pend_d    = 1'b0;
			end
			held_d       = value;
			held_valid_d = 1'b1;
		end
	end

	assign push = accept && (ev.emit || ev.inc_ovf);

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			esc_q        <= 1'b0;
			held_valid_q <= 1'b0;
			id_pend_q    <= 1'b0;
			raw_q        <= '0;
			held_q       <= 8'd0;
			sum_q        <= 8'd0;
		end else if (accept) begin
			in_frame_q   <= in_frame_d;
			esc_q        <= esc_d;
			held_valid_q <= held_valid_d;
			id_pend_q    <= id_pend_d;
			raw_q        <= raw_d;
			held_q       <= held_d;
			sum_q        <= sum_d;
		end
	end

endmodule

// ===== src/bsfr_queue.sv =====
// Short event queue that decouples the front end from the back end.
// Depends on bsfr_pkg.
module bsfr_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  bsfr_pkg::event_t                 push_ev,
	input  logic                             pop,
	output logic                             full,
	output logic                             not_empty,
	output bsfr_pkg::event_t                 head_ev,
	output logic [bsfr_pkg::QCNT_W-1:0]      count
);

	bsfr_pkg::event_t                mem_q [bsfr_pkg::QUEUE_DEPTH];
	logic [bsfr_pkg::QPTR_W-1:0]     wr_q, rd_q;
	logic [bsfr_pkg::QCNT_W-1:0]     cnt_q;

	assign full      = (cnt_q == bsfr_pkg::QCNT_W'(bsfr_pkg::QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head_ev   = mem_q[rd_q];
	assign count     = cnt_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_ev;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + bsfr_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + bsfr_pkg::QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + bsfr_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - bsfr_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/bsfr_back.sv =====
// Back end: applies counter steps and drives the output register.
// Depends on bsfr_pkg; drains bsfr_queue.
module bsfr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ev_valid,
	input  bsfr_pkg::event_t     ev,
	output logic                 pop,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 kind,
	output logic [7:0]           data_byte,
	output logic                 is_id,
	output logic [2:0]           status,
	output logic [31:0]          frames_total,
	output logic [31:0]          frames_good,
	output logic [31:0]          overflows
);

	logic        valid_q, kind_q, is_id_q;
	logic [7:0]  data_q;
	logic [2:0]  status_q;
	logic [31:0] total_q, good_q, ovf_q;

	// Take the next event once the output register is free or being emptied.
	assign pop = ev_valid && (!valid_q || out_ready);

	// Output register valid flag and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			total_q <= '0;
			good_q  <= '0;
			ovf_q   <= '0;
		end else begin
			if (pop) begin
				valid_q <= ev.emit;
				total_q <= total_q + 32'(ev.inc_total);
				good_q  <= good_q + 32'(ev.inc_good);
				ovf_q   <= ovf_q + 32'(ev.inc_ovf);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (pop && ev.emit) begin
			kind_q   <= ev.kind;
			data_q   <= ev.data_byte;
			is_id_q  <= ev.is_id;
			status_q <= ev.status;
		end
	end

	// Counters stay put while an item waits, so they are shown directly.
	assign out_valid    = valid_q;
	assign kind         = kind_q;
	assign data_byte    = data_q;
	assign is_id        = is_id_q;
	assign status       = status_q;
	assign frames_total = total_q;
	assign frames_good  = good_q;
	assign overflows    = ovf_q;

endmodule
